// File: rtl/vsae_pkg.sv
// Shared types, constants and lookup functions for the vital-sign alarm escalator.
// No dependencies; every other file of the block refers to this package by scoped names.
package vsae_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int PATTERN_STEPS = 10;
    localparam int LEVEL_COUNT   = 5;

    localparam int STEP_WIDTH  = $clog2(PATTERN_STEPS);
    localparam int LEVEL_WIDTH = 3;

    // Sensor machine state codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ALARM = 2'd1;
    localparam logic [1:0] ST_CRIT  = 2'd2;

    localparam logic [LEVEL_WIDTH-1:0] NORMAL_LEVEL = 3'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_OXYGEN_BELOW = 3'd0;
    localparam logic [2:0] REG_TEMP_LOW     = 3'd1;
    localparam logic [2:0] REG_TEMP_HIGH    = 3'd2;
    localparam logic [2:0] REG_PERSIST      = 3'd3;
    localparam logic [2:0] REG_CRIT_TONE    = 3'd4;
    localparam logic [2:0] REG_BEEP_TONE    = 3'd5;
    localparam logic [2:0] REG_SHORT_GAP    = 3'd6;
    localparam logic [2:0] REG_LONG_GAP     = 3'd7;

    // Register reset values.
    localparam logic [12:0] RST_OXYGEN_BELOW = 13'd2730;
    localparam logic [5:0]  RST_TEMP_LOW     = 6'd11;
    localparam logic [5:0]  RST_TEMP_HIGH    = 6'd28;
    localparam logic [15:0] RST_PERSIST      = 16'd30000;
    localparam logic [14:0] RST_CRIT_TONE    = 15'd2000;
    localparam logic [14:0] RST_BEEP_TONE    = 15'd1319;
    localparam logic [9:0]  RST_SHORT_GAP    = 10'd163;
    localparam logic [9:0]  RST_LONG_GAP     = 10'd325;

    localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(PATTERN_STEPS - 1);

    typedef logic [TIME_WIDTH-1:0] time_t;

    // Per-sensor status handed from a sensor machine to the top level.
    typedef struct packed {
        logic [1:0] state;    // state after this item, timeout included
        logic       cleared;  // the machine went back to ok on this item
    } sensor_status_t;

    // Beats per minute for a heart-rate level; levels past the table read 150.
    function automatic logic [7:0] level_bpm(input logic [LEVEL_WIDTH-1:0] level);
        logic [7:0] bpm;
        case (level)
            3'd0:    bpm = 8'd45;
            3'd1:    bpm = 8'd60;
            3'd2:    bpm = 8'd80;
            3'd3:    bpm = 8'd110;
            default: bpm = 8'd150;
        endcase
        return bpm;
    endfunction

    // A step is silent every third position (step mod 3 == 2) and on the last step.
    function automatic logic step_silent(input logic [STEP_WIDTH-1:0] step);
        logic mod3_is_two;
        mod3_is_two = 1'b0;
        for (int k = 2; k < (1 << STEP_WIDTH); k += 3) begin
            if (step == STEP_WIDTH'(k)) begin
                mod3_is_two = 1'b1;
            end
        end
        return mod3_is_two || (step >= LAST_STEP);
    endfunction

endpackage

// File: rtl/vsae_sensor_fsm.sv
// One ok/alarm/critical machine with its alarm start time and persistence timeout.
// Depends on vsae_pkg for state codes, the time type and the status struct.
module vsae_sensor_fsm (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_fire,
    input  logic                   sample_en,
    input  logic                   cond,
    input  vsae_pkg::time_t        time_next,
    input  logic [15:0]            persist_ms,
    output vsae_pkg::sensor_status_t status
);

    logic [1:0]      state_reg;
    vsae_pkg::time_t start_reg;
    logic [1:0]      state_mid;
    vsae_pkg::time_t start_next;
    logic [1:0]      state_next;
    logic            cleared;
    vsae_pkg::time_t held;

    always_comb begin
        state_mid  = state_reg;
        start_next = start_reg;
        cleared    = 1'b0;
        if (sample_en) begin
            if (cond && state_reg == vsae_pkg::ST_OK) begin
                state_mid  = vsae_pkg::ST_ALARM;
                start_next = time_next;
            end else if (!cond && state_reg != vsae_pkg::ST_OK) begin
                state_mid = vsae_pkg::ST_OK;
                cleared   = 1'b1;
            end
        end
        held       = time_next - start_next;
        state_next = state_mid;
        if (state_mid == vsae_pkg::ST_ALARM &&
            held >= vsae_pkg::TIME_WIDTH'(persist_ms)) begin
            state_next = vsae_pkg::ST_CRIT;
        end
    end

    assign status.state   = state_next;
    assign status.cleared = cleared;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsae_pkg::ST_OK;
            start_reg <= '0;
        end else if (item_fire) begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

endmodule

// File: rtl/vsae_tone.sv
// Buzzer tone selection and the alarm beep pattern sequencer.
// Depends on vsae_pkg for state codes, pattern constants and the step table.
module vsae_tone (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_fire,
    input  logic [1:0]                    worst,
    input  logic                          any_cleared,
    input  vsae_pkg::time_t               time_next,
    input  logic [14:0]                   critical_tone_hz,
    input  logic [14:0]                   beep_tone_hz,
    input  logic [9:0]                    short_gap_ms,
    input  logic [9:0]                    long_gap_ms,
    output logic [14:0]                   tone_next
);

    logic [vsae_pkg::STEP_WIDTH-1:0] step_reg;
    logic [vsae_pkg::STEP_WIDTH-1:0] step_next;
    vsae_pkg::time_t                 last_step_reg;
    vsae_pkg::time_t                 last_step_next;
    logic [14:0]                     tone_reg;
    logic [14:0]                     tone_base;
    logic [9:0]                      gap;
    logic                            step_due;

    always_comb begin
        // A machine returning to ok silences the buzzer before the pattern runs.
        tone_base      = any_cleared ? 15'd0 : tone_reg;
        gap            = (step_reg >= vsae_pkg::LAST_STEP) ? long_gap_ms : short_gap_ms;
        step_due       = (time_next - last_step_reg) >= vsae_pkg::TIME_WIDTH'(gap);
        step_next      = step_reg;
        last_step_next = last_step_reg;
        tone_next      = tone_base;
        unique case (worst)
            vsae_pkg::ST_OK: begin
                tone_next = 15'd0;
            end
            vsae_pkg::ST_ALARM: begin
                if (step_due) begin
                    last_step_next = time_next;
                    tone_next      = vsae_pkg::step_silent(step_reg) ? 15'd0 : beep_tone_hz;
                    step_next      = (step_reg >= vsae_pkg::LAST_STEP) ?
                                     '0 : step_reg + 1'b1;
                end
            end
            default: begin
                tone_next = critical_tone_hz;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            last_step_reg <= '0;
            tone_reg      <= '0;
        end else if (item_fire) begin
            step_reg      <= step_next;
            last_step_reg <= last_step_next;
            tone_reg      <= tone_next;
        end
    end

endmodule

// File: rtl/vital_sign_alarm_escalator_top.sv
// Top level of the vital-sign alarm escalator: input register, sensor machines, tone logic
// and result register. Depends on vsae_pkg, vsae_sensor_fsm and vsae_tone.
//
// Usage: one instance watches one patient. Each input beat on the s_ channel carries the
// milliseconds elapsed since the previous beat, the heart-rate button level, and an oxygen
// and a temperature sample, each with its own valid flag. Every input beat produces exactly
// one result beat on the m_ channel with the three sensor states, their worst, the heart
// level and its rate, the buzzer tone and the temperature-seen flag.
// From input acceptance to the result appearing on m_tvalid, the accepting edge loads the
// input register, and a later item_fire edge loads the result register through the update
// logic, once that register is free or draining.
// Throughput is one beat per cycle while the receiver keeps m_tready high; the time counter,
// the sensor machines and the pattern sequencer all update together on each processed beat.
// When the receiver stalls, the result register holds its beat and the input register
// keeps one more beat, after which s_tready drops until the result is taken.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready, and must only
// be written while no beat is in flight. After aresetn (synchronous, active low) all state
// returns to ok, the heart level to the normal level, time to zero, and every
// configuration register to its default.
module vital_sign_alarm_escalator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat, from bit 0: elapsed_ms[7:0], button_pressed, oxygen_valid,
    // oxygen_raw[11:0], temp_valid, temp_raw[5:0], three zero bits.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result beat, from bit 0: overall_state[1:0], heart_state[1:0], oxygen_state[1:0],
    // temperature_state[1:0], heart_level[2:0], beats_per_minute[7:0], tone_hz[14:0],
    // temp_seen, five zero bits.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [12:0] oxygen_below_reg;
    logic [5:0]  temp_low_reg;
    logic [5:0]  temp_high_reg;
    logic [15:0] persist_reg;
    logic [14:0] crit_tone_reg;
    logic [14:0] beep_tone_reg;
    logic [9:0]  short_gap_reg;
    logic [9:0]  long_gap_reg;

    // Pipeline registers.
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        item_fire;

    // Item state.
    vsae_pkg::time_t                time_reg;
    vsae_pkg::time_t                time_next;
    logic [vsae_pkg::LEVEL_WIDTH-1:0] level_reg;
    logic [vsae_pkg::LEVEL_WIDTH-1:0] level_next;
    logic                           button_reg;
    logic                           seen_reg;
    logic                           seen_next;

    // Unpacked input fields.
    logic [7:0]  elapsed_ms;
    logic        button_pressed;
    logic        oxygen_valid;
    logic [11:0] oxygen_raw;
    logic        temp_valid;
    logic [5:0]  temp_raw;

    vsae_pkg::sensor_status_t heart_status;
    vsae_pkg::sensor_status_t oxygen_status;
    vsae_pkg::sensor_status_t temp_status;
    logic [1:0]  worst;
    logic [14:0] tone_next;
    logic        oxygen_cond;
    logic        temp_cond;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oxygen_below_reg <= vsae_pkg::RST_OXYGEN_BELOW;
            temp_low_reg     <= vsae_pkg::RST_TEMP_LOW;
            temp_high_reg    <= vsae_pkg::RST_TEMP_HIGH;
            persist_reg      <= vsae_pkg::RST_PERSIST;
            crit_tone_reg    <= vsae_pkg::RST_CRIT_TONE;
            beep_tone_reg    <= vsae_pkg::RST_BEEP_TONE;
            short_gap_reg    <= vsae_pkg::RST_SHORT_GAP;
            long_gap_reg     <= vsae_pkg::RST_LONG_GAP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vsae_pkg::REG_OXYGEN_BELOW: oxygen_below_reg <= cfg_data[12:0];
                vsae_pkg::REG_TEMP_LOW:     temp_low_reg     <= cfg_data[5:0];
                vsae_pkg::REG_TEMP_HIGH:    temp_high_reg    <= cfg_data[5:0];
                vsae_pkg::REG_PERSIST:      persist_reg      <= cfg_data;
                vsae_pkg::REG_CRIT_TONE:    crit_tone_reg    <= cfg_data[14:0];
                vsae_pkg::REG_BEEP_TONE:    beep_tone_reg    <= cfg_data[14:0];
                vsae_pkg::REG_SHORT_GAP:    short_gap_reg    <= cfg_data[9:0];
                vsae_pkg::REG_LONG_GAP:     long_gap_reg     <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // The held input beat is processed whenever the result register is free or draining.
    assign item_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || item_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    assign elapsed_ms     = in_data_reg[7:0];
    assign button_pressed = in_data_reg[8];
    assign oxygen_valid   = in_data_reg[9];
    assign oxygen_raw     = in_data_reg[21:10];
    assign temp_valid     = in_data_reg[22];
    assign temp_raw       = in_data_reg[28:23];

    // Time advances first; a rising button edge steps the heart level around the ring.
    always_comb begin
        time_next  = time_reg + vsae_pkg::TIME_WIDTH'(elapsed_ms);
        level_next = level_reg;
        if (button_pressed && !button_reg) begin
            level_next = (level_reg >= vsae_pkg::LEVEL_WIDTH'(vsae_pkg::LEVEL_COUNT - 1)) ?
                         '0 : level_reg + 1'b1;
        end
        seen_next   = seen_reg || temp_valid;
        oxygen_cond = {1'b0, oxygen_raw} < oxygen_below_reg;
        temp_cond   = (temp_raw < temp_low_reg) || (temp_raw > temp_high_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg   <= '0;
            level_reg  <= vsae_pkg::NORMAL_LEVEL;
            button_reg <= 1'b0;
            seen_reg   <= 1'b0;
        end else if (item_fire) begin
            time_reg   <= time_next;
            level_reg  <= level_next;
            button_reg <= button_pressed;
            seen_reg   <= seen_next;
        end
    end

    vsae_sensor_fsm u_heart (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_fire  (item_fire),
        .sample_en  (1'b1),
        .cond       (level_next != vsae_pkg::NORMAL_LEVEL),
        .time_next  (time_next),
        .persist_ms (persist_reg),
        .status     (heart_status)
    );

    vsae_sensor_fsm u_oxygen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_fire  (item_fire),
        .sample_en  (oxygen_valid),
        .cond       (oxygen_cond),
        .time_next  (time_next),
        .persist_ms (persist_reg),
        .status     (oxygen_status)
    );

    vsae_sensor_fsm u_temp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_fire  (item_fire),
        .sample_en  (temp_valid),
        .cond       (temp_cond),
        .time_next  (time_next),
        .persist_ms (persist_reg),
        .status     (temp_status)
    );

    // Worst of the three states; the codes are ordered by severity.
    always_comb begin
        worst = heart_status.state;
        if (oxygen_status.state > worst) begin
            worst = oxygen_status.state;
        end
        if (temp_status.state > worst) begin
            worst = temp_status.state;
        end
    end

    vsae_tone u_tone (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_fire        (item_fire),
        .worst            (worst),
        .any_cleared      (heart_status.cleared || oxygen_status.cleared ||
                           temp_status.cleared),
        .time_next        (time_next),
        .critical_tone_hz (crit_tone_reg),
        .beep_tone_hz     (beep_tone_reg),
        .short_gap_ms     (short_gap_reg),
        .long_gap_ms      (long_gap_reg),
        .tone_next        (tone_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            out_data_reg <= {5'd0, seen_next, tone_next, vsae_pkg::level_bpm(level_next),
                             level_next, temp_status.state, oxygen_status.state,
                             heart_status.state, worst};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result beat reporting critical drives the configured steady tone.
    a_crit_tone : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == vsae_pkg::ST_CRIT) |-> m_tdata[33:19] == crit_tone_reg)
        else $error("critical result without the critical tone");

    // A result beat reporting ok is silent.
    a_ok_silent : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == vsae_pkg::ST_OK) |-> m_tdata[33:19] == 15'd0)
        else $error("tone driven while all sensors are ok");

    // The heart machine is ok exactly when the level is the normal one.
    a_heart_level : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:2] == vsae_pkg::ST_OK) ==
                      (m_tdata[10:8] == vsae_pkg::NORMAL_LEVEL)))
        else $error("heart state disagrees with heart level");

    // The overall state is never better than any single sensor.
    a_worst : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] >= m_tdata[3:2] && m_tdata[1:0] >= m_tdata[5:4] &&
                      m_tdata[1:0] >= m_tdata[7:6]))
        else $error("overall state below a sensor state");

    // Input is refused only while a beat already waits in the input register.
    a_no_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input refused without a waiting beat");

endmodule
